@@ hdl/pcpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpe_pkg
// Shared constants, codes and types of the parametric curve point evaluator.
// ----------------------------------------------------------------------------
package pcpe_pkg;

    // default build parameters
    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int ANGLE_FRAC_BITS_DEF   = 20;

    // field widths
    localparam int ANGLE_W  = 32;
    localparam int RADIUS_W = 32;
    localparam int OUT_W    = 48;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // angle constants in Q30
    localparam logic [32:0] TWO_PI_Q30        = 33'd6746518852;
    localparam logic [32:0] PI_Q30            = 33'd3373259426;
    localparam logic [32:0] HALF_PI_Q30       = 33'd1686629713;
    localparam logic [32:0] THREE_HALF_PI_Q30 = 33'd5059889139;
    localparam logic [31:0] GAIN_Q30          = 32'd652032874;

    // atan(2^-i) in Q30, truncated
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // curve kinds; the unused code behaves as a circle
    typedef enum logic [1:0] {
        CURVE_CIRCLE  = 2'd0,
        CURVE_ELLIPSE = 2'd1,
        CURVE_HELIX   = 2'd2
    } t_curve_kind;

    // register map, word index
    typedef enum logic [1:0] {
        REG_CURVE_KIND = 2'd0,
        REG_RADIUS_A   = 2'd1,
        REG_RADIUS_B   = 2'd2,
        REG_HELIX_STEP = 2'd3
    } t_reg_index;

    // configuration seen by the datapath
    typedef struct packed {
        logic [1:0]                 curve_kind;
        logic [RADIUS_W-1:0]        radius_a;
        logic [RADIUS_W-1:0]        radius_b;
        logic signed [RADIUS_W-1:0] helix_step;
    } t_cfg;

    // result of one request
    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic signed [OUT_W-1:0] pos_z;
        logic signed [OUT_W-1:0] vel_x;
        logic signed [OUT_W-1:0] vel_y;
        logic signed [OUT_W-1:0] vel_z;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/pcpe_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpe_pipe
// Angle reduction, CORDIC and radius scaling pipeline; one request per cycle,
// every stage advances together on i_en.
// ----------------------------------------------------------------------------
module pcpe_pipe #(
    parameter int CORDIC_ITERATIONS = pcpe_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = pcpe_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic signed [pcpe_pkg::ANGLE_W-1:0]   i_angle,
    input  wire pcpe_pkg::t_cfg                        i_cfg,
    output logic                                       o_valid,
    output pcpe_pkg::t_result                          o_result
);

    localparam int AW    = pcpe_pkg::ANGLE_W;
    localparam int RW    = pcpe_pkg::RADIUS_W;
    localparam int OW    = pcpe_pkg::OUT_W;
    localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int ZW    = 33 + SHIFT;
    localparam int NIT   = CORDIC_ITERATIONS;
    localparam int CW    = 33;
    localparam int PW    = 64;
    localparam int TRW   = PW - 30;
    localparam int HRW   = PW - ANGLE_FRAC_BITS;

    localparam logic [ZW-1:0] Z_OFFSET    = ZW'(pcpe_pkg::TWO_PI_Q30) << (SHIFT - 1);
    localparam logic [PW-1:0] ROUND_TRIG  = PW'(1) << 29;
    localparam logic [PW-1:0] ROUND_HELIX = PW'(1) << (ANGLE_FRAC_BITS - 1);
    localparam logic [PW-1:0] SAT_POS     = (PW'(1) << (OW - 1)) - PW'(1);
    localparam logic [PW-1:0] SAT_NEG     = PW'(1) << (OW - 1);

    // ---------------------------------------------------------------- entry
    // widen to Q30 and add a multiple of two pi so the value is positive
    logic signed [ZW-1:0] w_t_ext;
    logic [ZW-1:0]        n_entry_z;

    assign w_t_ext   = ZW'(i_angle);
    assign n_entry_z = $unsigned(w_t_ext <<< SHIFT) + Z_OFFSET;

    logic [SHIFT:0]          r_rd_valid;
    logic [ZW-1:0]           r_rd_z [SHIFT+1];
    logic signed [AW-1:0]    r_rd_t [SHIFT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_rd_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_z[0] <= n_entry_z;
            r_rd_t[0] <= i_angle;
        end
    end

    // ------------------------------------------------------ modulo two pi
    // restoring reduction, one multiple of two pi per stage
    for (genvar k = 0; k < SHIFT; k++) begin : g_reduce
        localparam logic [ZW-1:0] MOD_K = ZW'(pcpe_pkg::TWO_PI_Q30) << (SHIFT - 1 - k);
        logic [ZW-1:0] n_z;

        assign n_z = (r_rd_z[k] >= MOD_K) ? (r_rd_z[k] - MOD_K) : r_rd_z[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rd_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_rd_valid[k+1] <= r_rd_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rd_z[k+1] <= n_z;
                r_rd_t[k+1] <= r_rd_t[k];
            end
        end
    end

    // ----------------------------------------------------------------- fold
    // bring [0, 2pi) into [-pi/2, pi/2], flipping cos and sin across pi
    logic [32:0]        w_u;
    logic signed [33:0] w_u_s;
    logic signed [33:0] w_fold;
    logic               w_flip;

    assign w_u   = r_rd_z[SHIFT][32:0];
    assign w_u_s = $signed({1'b0, w_u});

    always_comb begin
        w_flip = 1'b0;
        w_fold = w_u_s;
        if (w_u > pcpe_pkg::HALF_PI_Q30 && w_u < pcpe_pkg::THREE_HALF_PI_Q30) begin
            w_flip = 1'b1;
            w_fold = w_u_s - $signed({1'b0, pcpe_pkg::PI_Q30});
        end else if (w_u >= pcpe_pkg::THREE_HALF_PI_Q30) begin
            w_fold = w_u_s - $signed({1'b0, pcpe_pkg::TWO_PI_Q30});
        end
    end

    logic [NIT:0]         r_c_valid;
    logic signed [CW-1:0] r_c_x [NIT+1];
    logic signed [CW-1:0] r_c_y [NIT+1];
    logic signed [CW-1:0] r_c_z [NIT+1];
    logic [NIT:0]         r_c_flip;
    logic signed [AW-1:0] r_c_t [NIT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_c_valid[0] <= r_rd_valid[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_x[0]    <= CW'(pcpe_pkg::GAIN_Q30);
            r_c_y[0]    <= '0;
            r_c_z[0]    <= CW'(w_fold);
            r_c_flip[0] <= w_flip;
            r_c_t[0]    <= r_rd_t[SHIFT];
        end
    end

    // --------------------------------------------------------------- cordic
    // rotation mode, one micro-rotation per stage
    for (genvar i = 0; i < NIT; i++) begin : g_cordic
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;
        logic signed [CW-1:0] w_atan;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;

        assign w_dx   = r_c_y[i] >>> i;
        assign w_dy   = r_c_x[i] >>> i;
        assign w_atan = $signed(CW'(pcpe_pkg::ATAN_Q30[i]));

        always_comb begin
            if (!r_c_z[i][CW-1]) begin
                n_x = r_c_x[i] - w_dx;
                n_y = r_c_y[i] + w_dy;
                n_z = r_c_z[i] - w_atan;
            end else begin
                n_x = r_c_x[i] + w_dx;
                n_y = r_c_y[i] - w_dy;
                n_z = r_c_z[i] + w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_c_valid[i+1] <= r_c_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c_x[i+1]    <= n_x;
                r_c_y[i+1]    <= n_y;
                r_c_z[i+1]    <= n_z;
                r_c_flip[i+1] <= r_c_flip[i];
                r_c_t[i+1]    <= r_c_t[i];
            end
        end
    end

    // ------------------------------------------------------------ magnitudes
    // sign and magnitude of cos, sin, step and t
    logic signed [CW-1:0] w_neg_x;
    logic signed [CW-1:0] w_neg_y;
    logic [CW-1:0]        w_abs_x;
    logic [CW-1:0]        w_abs_y;
    logic [AW:0]          w_abs_st;
    logic [AW:0]          w_abs_t;

    assign w_neg_x  = -r_c_x[NIT];
    assign w_neg_y  = -r_c_y[NIT];
    assign w_abs_x  = r_c_x[NIT][CW-1] ? w_neg_x : r_c_x[NIT];
    assign w_abs_y  = r_c_y[NIT][CW-1] ? w_neg_y : r_c_y[NIT];
    assign w_abs_st = i_cfg.helix_step[RW-1] ? (-(AW+1)'(i_cfg.helix_step))
                                             : (AW+1)'(i_cfg.helix_step);
    assign w_abs_t  = r_c_t[NIT][AW-1] ? (-(AW+1)'(r_c_t[NIT])) : (AW+1)'(r_c_t[NIT]);

    logic          r_a_valid;
    logic [31:0]   r_a_mx;
    logic [31:0]   r_a_my;
    logic          r_a_sx;
    logic          r_a_sy;
    logic [AW-1:0] r_a_ms;
    logic [AW-1:0] r_a_mt;
    logic          r_a_hneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= r_c_valid[NIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mx   <= w_abs_x[31:0];
            r_a_my   <= w_abs_y[31:0];
            r_a_sx   <= r_c_x[NIT][CW-1] ^ r_c_flip[NIT];
            r_a_sy   <= r_c_y[NIT][CW-1] ^ r_c_flip[NIT];
            r_a_ms   <= w_abs_st[AW-1:0];
            r_a_mt   <= w_abs_t[AW-1:0];
            r_a_hneg <= i_cfg.helix_step[RW-1] ^ r_c_t[NIT][AW-1];
        end
    end

    // ------------------------------------------------------------- products
    logic [RW-1:0] w_rb;
    logic [PW-1:0] w_p_xa;
    logic [PW-1:0] w_p_yb;
    logic [PW-1:0] w_p_ya;
    logic [PW-1:0] w_p_xb;
    logic [PW-1:0] w_p_z;

    assign w_rb   = (i_cfg.curve_kind == pcpe_pkg::CURVE_ELLIPSE) ? i_cfg.radius_b
                                                                  : i_cfg.radius_a;
    assign w_p_xa = r_a_mx * i_cfg.radius_a;
    assign w_p_yb = r_a_my * w_rb;
    assign w_p_ya = r_a_my * i_cfg.radius_a;
    assign w_p_xb = r_a_mx * w_rb;
    assign w_p_z  = r_a_ms * r_a_mt;

    logic          r_m_valid;
    logic [PW-1:0] r_m_xa;
    logic [PW-1:0] r_m_yb;
    logic [PW-1:0] r_m_ya;
    logic [PW-1:0] r_m_xb;
    logic [PW-1:0] r_m_z;
    logic          r_m_sx;
    logic          r_m_sy;
    logic          r_m_hneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_xa   <= w_p_xa;
            r_m_yb   <= w_p_yb;
            r_m_ya   <= w_p_ya;
            r_m_xb   <= w_p_xb;
            r_m_z    <= w_p_z;
            r_m_sx   <= r_a_sx;
            r_m_sy   <= r_a_sy;
            r_m_hneg <= r_a_hneg;
        end
    end

    // ------------------------------------------------------------- rounding
    // round to nearest on magnitudes, ties away from zero
    logic [PW-1:0] w_rnd_xa;
    logic [PW-1:0] w_rnd_yb;
    logic [PW-1:0] w_rnd_ya;
    logic [PW-1:0] w_rnd_xb;
    logic [PW-1:0] w_rnd_z;

    assign w_rnd_xa = (r_m_xa + ROUND_TRIG) >> 30;
    assign w_rnd_yb = (r_m_yb + ROUND_TRIG) >> 30;
    assign w_rnd_ya = (r_m_ya + ROUND_TRIG) >> 30;
    assign w_rnd_xb = (r_m_xb + ROUND_TRIG) >> 30;
    assign w_rnd_z  = (r_m_z + ROUND_HELIX) >> ANGLE_FRAC_BITS;

    logic           r_r_valid;
    logic [TRW-1:0] r_r_xa;
    logic [TRW-1:0] r_r_yb;
    logic [TRW-1:0] r_r_ya;
    logic [TRW-1:0] r_r_xb;
    logic [HRW-1:0] r_r_z;
    logic           r_r_sx;
    logic           r_r_sy;
    logic           r_r_hneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (i_en) begin
            r_r_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r_xa   <= w_rnd_xa[TRW-1:0];
            r_r_yb   <= w_rnd_yb[TRW-1:0];
            r_r_ya   <= w_rnd_ya[TRW-1:0];
            r_r_xb   <= w_rnd_xb[TRW-1:0];
            r_r_z    <= w_rnd_z[HRW-1:0];
            r_r_sx   <= r_m_sx;
            r_r_sy   <= r_m_sy;
            r_r_hneg <= r_m_hneg;
        end
    end

    // --------------------------------------------------------------- format
    // apply signs, saturate helix z, zero z outside helix mode
    logic [PW-1:0]        w_hz;
    logic [PW-1:0]        w_hz_sat;
    logic [OW-1:0]        w_xa;
    logic [OW-1:0]        w_yb;
    logic [OW-1:0]        w_ya;
    logic [OW-1:0]        w_xb;
    logic [OW-1:0]        w_zm;
    logic                 w_helix;
    pcpe_pkg::t_result    n_fmt;

    assign w_hz    = PW'(r_r_z);
    assign w_xa    = OW'(r_r_xa);
    assign w_yb    = OW'(r_r_yb);
    assign w_ya    = OW'(r_r_ya);
    assign w_xb    = OW'(r_r_xb);
    assign w_zm    = w_hz_sat[OW-1:0];
    assign w_helix = (i_cfg.curve_kind == pcpe_pkg::CURVE_HELIX);

    always_comb begin
        if (r_r_hneg) begin
            w_hz_sat = (w_hz > SAT_NEG) ? SAT_NEG : w_hz;
        end else begin
            w_hz_sat = (w_hz > SAT_POS) ? SAT_POS : w_hz;
        end
        n_fmt.pos_x = r_r_sx ? -w_xa : w_xa;
        n_fmt.pos_y = r_r_sy ? -w_yb : w_yb;
        n_fmt.vel_x = r_r_sy ? w_ya : -w_ya;
        n_fmt.vel_y = r_r_sx ? -w_xb : w_xb;
        if (w_helix) begin
            n_fmt.pos_z = r_r_hneg ? -w_zm : w_zm;
            n_fmt.vel_z = OW'(i_cfg.helix_step);
        end else begin
            n_fmt.pos_z = '0;
            n_fmt.vel_z = '0;
        end
    end

    logic              r_fmt_valid;
    pcpe_pkg::t_result r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_valid <= 1'b0;
        end else if (i_en) begin
            r_fmt_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fmt <= n_fmt;
        end
    end

    assign o_valid  = r_fmt_valid;
    assign o_result = r_fmt;

endmodule
`default_nettype wire

@@ hdl/parametric_curve_point_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// parametric_curve_point_evaluator
// Point and first derivative on a circle, ellipse or helix for a curve
// parameter t, with an APB register port for the curve set-up.
// ----------------------------------------------------------------------------
// The block takes one angle request per clock while o_in_stall is low and
// returns each result (pos and vel, Q32.16, 48 bits) after it has passed
// an entry register that widens t, the modulo reduction stages that take
// off multiples of two pi, a fold stage, the CORDIC micro-rotation stages,
// then magnitude, multiply, rounding, format and output register stages. A
// stalled output fills a one-entry skid register, after which the input
// is stalled until the result is taken. Registers may only be changed
// while no request is in flight.
module parametric_curve_point_evaluator #(
    parameter int CORDIC_ITERATIONS = pcpe_pkg::CORDIC_ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS   = pcpe_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // angle request channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [pcpe_pkg::ANGLE_W-1:0]   i_angle,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_pos_x,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_pos_y,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_pos_z,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_vel_x,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_vel_y,
    output logic signed [pcpe_pkg::OUT_W-1:0]          o_vel_z,
    // register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [pcpe_pkg::APB_AW-1:0]           paddr,
    input  wire logic [pcpe_pkg::APB_DW-1:0]           pwdata,
    output logic [pcpe_pkg::APB_DW-1:0]                prdata,
    output logic                                       pready
);

    localparam int DW = pcpe_pkg::APB_DW;

    // ------------------------------------------------------------ registers
    pcpe_pkg::t_cfg        r_cfg;
    pcpe_pkg::t_reg_index  w_reg_idx;
    logic                  w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = pcpe_pkg::t_reg_index'(paddr[3:2]);
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.curve_kind <= pcpe_pkg::CURVE_CIRCLE;
            r_cfg.radius_a   <= 32'h0001_0000;
            r_cfg.radius_b   <= 32'h0001_0000;
            r_cfg.helix_step <= 32'sh0001_0000;
        end else if (w_wr) begin
            case (w_reg_idx)
                pcpe_pkg::REG_CURVE_KIND: r_cfg.curve_kind <= pwdata[1:0];
                pcpe_pkg::REG_RADIUS_A:   r_cfg.radius_a   <= pwdata;
                pcpe_pkg::REG_RADIUS_B:   r_cfg.radius_b   <= pwdata;
                pcpe_pkg::REG_HELIX_STEP: r_cfg.helix_step <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_reg_idx)
            pcpe_pkg::REG_CURVE_KIND: prdata = DW'(r_cfg.curve_kind);
            pcpe_pkg::REG_RADIUS_A:   prdata = r_cfg.radius_a;
            pcpe_pkg::REG_RADIUS_B:   prdata = r_cfg.radius_b;
            pcpe_pkg::REG_HELIX_STEP: prdata = r_cfg.helix_step;
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------- datapath
    logic              w_en;
    logic              w_pipe_valid;
    pcpe_pkg::t_result w_pipe_result;
    logic              r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    pcpe_pipe #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_angle  (i_angle),
        .i_cfg    (r_cfg),
        .o_valid  (w_pipe_valid),
        .o_result (w_pipe_result)
    );

    // ---------------------------------------------------- output and skid
    pcpe_pkg::t_result r_out;
    pcpe_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              n_skid_valid;
    logic              w_take;
    logic              w_arrive;
    logic              w_out_load;
    logic              w_out_from_skid;
    logic              w_skid_load;

    assign w_take   = r_out_valid && !i_out_stall;
    assign w_arrive = w_en && w_pipe_valid;

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_out_load      = 1'b0;
        w_out_from_skid = 1'b0;
        w_skid_load     = 1'b0;
        if (r_skid_valid) begin
            if (w_take) begin
                n_skid_valid    = 1'b0;
                w_out_from_skid = 1'b1;
            end
        end else if (w_arrive) begin
            if (!r_out_valid || w_take) begin
                w_out_load  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_skid_load  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out <= r_skid;
        end else if (w_out_load) begin
            r_out <= w_pipe_result;
        end
        if (w_skid_load) begin
            r_skid <= w_pipe_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out.pos_x;
    assign o_pos_y     = r_out.pos_y;
    assign o_pos_z     = r_out.pos_z;
    assign o_vel_x     = r_out.vel_x;
    assign o_vel_y     = r_out.vel_y;
    assign o_vel_z     = r_out.vel_z;

endmodule
`default_nettype wire

@@ hdl/pcpe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpe_checker
// Port-level checks of the curve evaluator's input and result channels.
// ----------------------------------------------------------------------------
module pcpe_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  o_in_stall,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_stall,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_pos_x,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_pos_y,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_pos_z,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_vel_x,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_vel_y,
    input wire logic signed [pcpe_pkg::OUT_W-1:0]     o_vel_z
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pos_x) &&
        $stable(o_pos_y) && $stable(o_pos_z) && $stable(o_vel_x) &&
        $stable(o_vel_y) && $stable(o_vel_z))
        else $error("result changed while stalled");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall without a stalled result");

    // an empty output never holds the input back
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind parametric_curve_point_evaluator pcpe_checker u_pcpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_pos_z     (o_pos_z),
    .o_vel_x     (o_vel_x),
    .o_vel_y     (o_vel_y),
    .o_vel_z     (o_vel_z)
);
`default_nettype wire

@@ tb/tb_parametric_curve_point_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parametric_curve_point_evaluator
// Self-checking bench for the curve point evaluator. A directed table walks
// the angle and radius extremes, every curve kind and the spare kind code,
// then random phases with fresh register settings stream angle requests with
// bursty input and a stalling receiver. Results are checked field by field
// against a bit-exact CORDIC model of the block in the bench or typed z, dz.
// ----------------------------------------------------------------------------
module tb_parametric_curve_point_evaluator;

    import pcpe_pkg::*;

    // build and timing figures
    localparam int CORDIC_STEPS = CORDIC_ITERATIONS_DEF;
    localparam int ANGLE_FRAC   = ANGLE_FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = (30 - ANGLE_FRAC) + CORDIC_STEPS + 7;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 20000;

    // fixed-point constants of the angle path, Q30
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam longint ANGLE_SCALE = 64'sd1 << (30 - ANGLE_FRAC);

    // atan(2^-i) in Q30, truncated
    localparam longint ATAN_TABLE [32] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127,
        63,        31,        15,        7,
        3,         1,         0,         0
    };

    // spare curve kind code, decoded as a circle
    localparam logic [1:0] CURVE_SPARE = 2'd3;

    // handy angles in Q12.20
    localparam logic [31:0] ANG_HALF_PI  = 32'd1647099;
    localparam logic [31:0] ANG_PI       = 32'd3294199;
    localparam logic [31:0] ANG_3HALF_PI = 32'd4941298;
    localparam logic [31:0] ANG_TWO_PI   = 32'd6588397;
    localparam int          QUARTER_TURN = 1647099;

    // receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    // directed stimulus row
    typedef struct {
        logic [1:0]  kind;
        logic [31:0] ra;
        logic [31:0] rb;
        logic [31:0] step;
        logic [31:0] angle;
        bit          typed;
        logic [47:0] z;
        logic [47:0] dz;
    } stim_row_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic signed [31:0] i_angle     = '0;
    logic               i_out_stall = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [APB_AW-1:0]  paddr       = '0;
    logic [APB_DW-1:0]  pwdata      = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [OUT_W-1:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [OUT_W-1:0] o_vel_x, o_vel_y, o_vel_z;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    t_cfg      curve_cfg;
    t_result   pending_points [$];
    stim_row_t dir_rows [$];
    int        mismatch_count = 0;
    int        burst_left     = 0;
    int        gap_max        = 0;
    int        rx_mode        = RX_FREE;
    int        rx_tick        = 0;
    int        hold_asked     = 0;
    int        hold_done      = 0;
    int        hold_left      = 0;

    parametric_curve_point_evaluator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_angle     (i_angle),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_vel_z     (o_vel_z),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // radius (Q16.16) times a Q30 trig value, rounded on the magnitude
    function automatic logic [47:0] scaled_trig(input logic [31:0] r, input longint c,
                                                input logic negate);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = (c < 0) ? 64'(-c) : 64'(c);
        prod = (64'(r) * mag + (64'd1 << 29)) >> 30;
        if (negate != (c < 0))
            return 48'(~prod + 64'd1);
        return prod[47:0];
    endfunction

    // point and derivative for one angle under the given set-up
    function automatic t_result curve_point(input logic signed [31:0] t, input t_cfg c);
        longint             ang;
        longint             cx;
        longint             cy;
        longint             dx;
        longint             dy;
        logic               flip;
        logic               neg;
        logic [31:0]        rb;
        logic signed [31:0] st;
        logic [63:0]        ms;
        logic [63:0]        mt;
        logic [63:0]        prod;
        t_result            r;

        // reduce to [-pi, pi), then fold into [-pi/2, pi/2]
        ang = longint'(t) * ANGLE_SCALE;
        ang = ang % Q30_TWO_PI;
        if (ang < 0)
            ang += Q30_TWO_PI;
        if (ang >= Q30_PI)
            ang -= Q30_TWO_PI;
        flip = 1'b0;
        if (ang > Q30_HALF_PI) begin
            ang -= Q30_PI;
            flip = 1'b1;
        end else if (ang < -Q30_HALF_PI) begin
            ang += Q30_PI;
            flip = 1'b1;
        end

        // rotation-mode micro-rotations
        cx = Q30_GAIN;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx  -= dx;
                cy  += dy;
                ang -= ATAN_TABLE[i];
            end else begin
                cx  += dx;
                cy  -= dy;
                ang += ATAN_TABLE[i];
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end

        rb = (c.curve_kind == CURVE_ELLIPSE) ? c.radius_b : c.radius_a;
        r.pos_x = scaled_trig(c.radius_a, cx, 1'b0);
        r.pos_y = scaled_trig(rb, cy, 1'b0);
        r.vel_x = scaled_trig(c.radius_a, cy, 1'b1);
        r.vel_y = scaled_trig(rb, cx, 1'b0);

        // helix rise, saturated to 48 bits
        if (c.curve_kind == CURVE_HELIX) begin
            st   = c.helix_step;
            neg  = (st < 0) != (t < 0);
            ms   = (st < 0) ? 64'(-longint'(st)) : 64'(longint'(st));
            mt   = (t < 0) ? 64'(-longint'(t)) : 64'(longint'(t));
            prod = (ms * mt + (64'd1 << (ANGLE_FRAC - 1))) >> ANGLE_FRAC;
            if (neg && prod > 64'h0000_8000_0000_0000)
                prod = 64'h0000_8000_0000_0000;
            if (!neg && prod > 64'h0000_7FFF_FFFF_FFFF)
                prod = 64'h0000_7FFF_FFFF_FFFF;
            r.pos_z = neg ? 48'(~prod + 64'd1) : prod[47:0];
            r.vel_z = {{16{st[31]}}, st};
        end else begin
            r.pos_z = '0;
            r.vel_z = '0;
        end
        return r;
    endfunction

    // random stimulus values
    function automatic logic [31:0] pick_angle();
        int          k;
        int          off;
        logic [31:0] a;
        case ($urandom_range(0, 3))
            0, 1: a = $urandom;
            2: begin
                // close to a quarter-turn fold boundary
                k   = int'($urandom_range(0, 2606)) - 1303;
                off = int'($urandom_range(0, 8)) - 4;
                a   = k * QUARTER_TURN + off;
            end
            default: a = int'($urandom_range(0, 6588397)) - 3294199;
        endcase
        return a;
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] ra, input logic [31:0] rb,
                           input logic [31:0] step, input logic [31:0] angle, input bit typed,
                           input logic [47:0] z, input logic [47:0] dz);
        stim_row_t row;
        row.kind  = kind;
        row.ra    = ra;
        row.rb    = rb;
        row.step  = step;
        row.angle = angle;
        row.typed = typed;
        row.z     = z;
        row.dz    = dz;
        dir_rows.push_back(row);
    endtask

    // apb write: setup then access, register taken when pready is high
    task automatic reg_write(input t_reg_index idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CURVE_KIND: curve_cfg.curve_kind = value[1:0];
            REG_RADIUS_A:   curve_cfg.radius_a   = value;
            REG_RADIUS_B:   curve_cfg.radius_b   = value;
            default:        curve_cfg.helix_step = value;
        endcase
    endtask

    // hold the input until every result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // new curve set-up, only with nothing in flight
    task automatic load_curve(input logic [1:0] kind, input logic [31:0] ra,
                              input logic [31:0] rb, input logic [31:0] step);
        wait_idle();
        reg_write(REG_CURVE_KIND, {30'd0, kind});
        reg_write(REG_RADIUS_A, ra);
        reg_write(REG_RADIUS_B, rb);
        reg_write(REG_HELIX_STEP, step);
    endtask

    // one angle request, sent in bursts with random gaps
    task automatic offer_angle(input logic [31:0] a, input t_result want);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_angle    <= a;
        do @(posedge i_clk); while (o_in_stall);
        pending_points.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: long hold on request, otherwise the phase's stall pattern
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_done != hold_asked) begin
            hold_done   <= hold_asked;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:  i_out_stall <= ((rx_tick % 11) < 4);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_points.size() == 0) begin
                $error("result with no request waiting");
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                check_field("pos_x", want.pos_x, o_pos_x);
                check_field("pos_y", want.pos_y, o_pos_y);
                check_field("pos_z", want.pos_z, o_pos_z);
                check_field("vel_x", want.vel_x, o_vel_x);
                check_field("vel_y", want.vel_y, o_vel_y);
                check_field("vel_z", want.vel_z, o_vel_z);
            end
        end
    end

    // stimulus
    initial begin
        stim_row_t row;
        t_result   want;
        int        drain_wait;
        logic [1:0] kind;

        // set-up after reset
        curve_cfg.curve_kind = CURVE_CIRCLE;
        curve_cfg.radius_a   = 32'h0001_0000;
        curve_cfg.radius_b   = 32'h0001_0000;
        curve_cfg.helix_step = 32'h0001_0000;

        // directed table: reset set-up first
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, 32'h0, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, 32'h1, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, 32'hFFFF_FFFF, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, 32'h7FFF_FFFF, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, 32'h8000_0000, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, ANG_HALF_PI, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, ANG_PI, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, -ANG_PI, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, ANG_3HALF_PI, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'h10000, 32'h10000, 32'h10000, ANG_TWO_PI, 0, 48'd0, 48'd0);
        // zero radius gives all-zero output
        add_row(CURVE_CIRCLE, 32'h0, 32'h0, 32'h10000, 32'h1234_5678, 1, 48'd0, 48'd0);
        // largest radius
        add_row(CURVE_CIRCLE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0010_0000, 0, 48'd0, 48'd0);
        add_row(CURVE_CIRCLE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFF0_0000, 0, 48'd0, 48'd0);
        // ellipse with lopsided axes
        add_row(CURVE_ELLIPSE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0020_0000, 0, 48'd0, 48'd0);
        add_row(CURVE_ELLIPSE, 32'h10000, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0, 48'd0, 48'd0);
        add_row(CURVE_ELLIPSE, 32'h20000, 32'h10000, 32'h0, ANG_HALF_PI, 0, 48'd0, 48'd0);
        // helix with zero radius: only z and dz are live
        add_row(CURVE_HELIX, 32'h0, 32'h0, 32'h0001_0000, 32'h0010_0000, 1,
                48'h0000_0001_0000, 48'h0000_0001_0000);
        add_row(CURVE_HELIX, 32'h0, 32'h0, 32'hFFFF_0000, 32'hFFE0_0000, 1,
                48'h0000_0002_0000, 48'hFFFF_FFFF_0000);
        add_row(CURVE_HELIX, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1,
                48'h0400_0000_0000, 48'hFFFF_8000_0000);
        // helix extremes, largest positive step at the angle extremes
        add_row(CURVE_HELIX, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 48'd0, 48'd0);
        add_row(CURVE_HELIX, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 48'd0, 48'd0);
        add_row(CURVE_HELIX, 32'h8000, 32'h0, 32'h0, 32'h0012_3456, 0, 48'd0, 48'd0);
        // spare kind code behaves as a circle
        add_row(CURVE_SPARE, 32'h30000, 32'h50000, 32'h20000, 32'h0030_0000, 0, 48'd0, 48'd0);
        add_row(CURVE_SPARE, 32'h30000, 32'h50000, 32'h20000, 32'hFFC0_0000, 0, 48'd0, 48'd0);

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        gap_max = 3;
        rx_mode <= RX_LIGHT;
        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.kind != curve_cfg.curve_kind || row.ra != curve_cfg.radius_a ||
                row.rb != curve_cfg.radius_b || row.step != curve_cfg.helix_step)
                load_curve(row.kind, row.ra, row.rb, row.step);
            if (row.typed) begin
                want       = '0;
                want.pos_z = row.z;
                want.vel_z = row.dz;
            end else begin
                want = curve_point(row.angle, curve_cfg);
            end
            offer_angle(row.angle, want);
        end

        // random phases, each with a fresh set-up
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0)
                load_curve(CURVE_ELLIPSE, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
            else if (phase == 1)
                load_curve(CURVE_HELIX, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
            else begin
                kind = 2'($urandom_range(0, 3));
                load_curve(kind, pick_radius(), pick_radius(), pick_step());
            end
            gap_max = (phase % 2 == 1) ? 0 : 6;
            rx_mode <= phase % 4;
            for (int n = 0; n < 75; n++) begin
                // receiver holds off while the input keeps coming
                if (phase == 2 && n == 20)
                    hold_asked <= hold_asked + 1;
                // sender pauses until everything is back
                if (phase == 5 && n == 30)
                    wait_idle();
                want = '0;
                begin
                    logic [31:0] a;
                    a = pick_angle();
                    offer_angle(a, curve_point(a, curve_cfg));
                end
            end
        end

        // drain and report
        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (pending_points.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            $error("%0d results never arrived", pending_points.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ parametric_curve_point_evaluator.f @@
hdl/pcpe_pkg.sv
hdl/pcpe_pipe.sv
hdl/parametric_curve_point_evaluator.sv
hdl/pcpe_checker.sv
tb/tb_parametric_curve_point_evaluator.sv
